### design/assert_macros.svh
// Assertion macros used by the port checker file.
// Depends on nothing; each macro expects clk and arst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("port check failed");

// next-cycle implication, off during reset
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("port check failed");

`endif

### design/mfb_pkg.sv
// Shared types and constants of the matrix multiply / backprop engine.
// No dependencies.
package mfb_pkg;

	localparam int DEF_MAX_DIM   = 8;
	localparam int DEF_ELEM_BITS = 16;
	localparam int DATA_W        = 32;
	localparam int DIM_W         = 4;
	localparam int CFG_IDX_W     = 2;
	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// command codes of an input word
	typedef enum logic [2:0] {
		CMD_LOAD_A  = 3'd0,
		CMD_LOAD_B  = 3'd1,
		CMD_LOAD_DC = 3'd2,
		CMD_FWD     = 3'd3,
		CMD_BWD     = 3'd4,
		CMD_READ    = 3'd5,
		CMD_CLEAR   = 3'd6
	} cmd_t;

	// read select codes
	typedef enum logic [1:0] {
		SEL_C  = 2'd0,
		SEL_GA = 2'd1,
		SEL_GB = 2'd2
	} sel_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS  = 2'd0,
		REG_INNER = 2'd1,
		REG_COLS  = 2'd2
	} reg_t;

	// compute pass: forward, gradA, gradB
	typedef enum logic [1:0] {
		MODE_FWD = 2'd0,
		MODE_BWA = 2'd1,
		MODE_BWB = 2'd2
	} mode_t;

	// controller -> datapath commands
	typedef struct packed {
		logic  accept;    // input word taken this cycle
		logic  issue;     // one multiply-accumulate step issued
		logic  first;     // first step of an output element
		logic  last;      // last step of an output element
		mode_t mode;
		logic  clr_en;    // zero one entry of each gradient memory
		logic  out_load;  // move read data into the output register
	} ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic busy;       // steps still in flight or write-back pending
		logic out_full;   // output register holds a word not taken this cycle
	} stat_t;

endpackage

### design/matmul_forward_backward.sv
// Top level of the matmul engine with backprop gradients.
// Depends on mfb_pkg, mfb_ctrl and mfb_dp.
//
//   channel | signals                                                | moves
//   --------+--------------------------------------------------------+-------------------
//   in      | in_valid/in_ready, cmd, row_index, col_index,          | one command word
//           | element_value, read_select                             |
//   out     | out_valid/out_ready, result_value                      | one read word
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data               | one register write
//
// Loads, cmd 7 and config writes leave the input open; a read closes it until
// its word moves into a free output register. Forward and backward (a gradA pass
// then a gradB pass) run one multiply-accumulate per cycle on a single multiplier
// and then drain the pipeline. Reset and the clear command run a sweep zeroing the
// gradient memories; no command word is taken during it.
module matmul_forward_backward #(
	parameter int MAX_DIM   = mfb_pkg::DEF_MAX_DIM,
	parameter int ELEM_BITS = mfb_pkg::DEF_ELEM_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        cmd,
	input  logic [2:0]                        row_index,
	input  logic [2:0]                        col_index,
	input  logic signed [ELEM_BITS-1:0]       element_value,
	input  logic [1:0]                        read_select,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mfb_pkg::DATA_W-1:0] result_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfb_pkg::DIM_W-1:0]         cfg_data
);
	localparam int IW = $clog2(MAX_DIM);
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	mfb_pkg::ctl_t  ctl;
	mfb_pkg::stat_t stat;
	logic [IW-1:0]  p_idx, q_idx, t_idx;
	logic [AW-1:0]  clr_addr;

	// config writes are accepted at any time
	assign cfg_ready = 1'b1;

	mfb_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.p_idx     (p_idx),
		.q_idx     (q_idx),
		.t_idx     (t_idx),
		.clr_addr  (clr_addr),
		.stat      (stat)
	);

	mfb_dp #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.p_idx         (p_idx),
		.q_idx         (q_idx),
		.t_idx         (t_idx),
		.clr_addr      (clr_addr),
		.cmd           (cmd),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.read_select   (read_select),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_value  (result_value)
	);

endmodule

### design/mfb_ctrl.sv
// Controller of the matmul engine: command decode, loop counters, clear sweep.
// Depends on mfb_pkg.
module mfb_ctrl #(
	parameter int MAX_DIM = mfb_pkg::DEF_MAX_DIM
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     cmd,
	input  logic                           cfg_valid,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfb_pkg::DIM_W-1:0]      cfg_data,
	output mfb_pkg::ctl_t                  ctl,
	output logic [$clog2(MAX_DIM)-1:0]     p_idx,
	output logic [$clog2(MAX_DIM)-1:0]     q_idx,
	output logic [$clog2(MAX_DIM)-1:0]     t_idx,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] clr_addr,
	input  mfb_pkg::stat_t                 stat
);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [4:0] {
		S_CLR   = 5'b00001,
		S_IDLE  = 5'b00010,
		S_RD    = 5'b00100,
		S_RUN   = 5'b01000,
		S_DRAIN = 5'b10000
	} state_t;

	state_t                    state_q, state_d;
	mfb_pkg::mode_t            mode_q, mode_d;
	logic [mfb_pkg::DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [IW-1:0]             p_q, q_q, t_q;
	logic [AW-1:0]             clr_q;
	logic [IW-1:0]             nr_m1, nk_m1, nc_m1;
	logic [IW-1:0]             lp, lq, lt;
	logic                      in_fire, t_end, q_end, p_end, clr_end;

	// dimension clamp: 0 acts as 1, above MAX_DIM acts as MAX_DIM
	function automatic logic [IW-1:0] dim_m1(input logic [mfb_pkg::DIM_W-1:0] r);
		logic [IW-1:0] v;
		if (r == '0)
			v = '0;
		else if (int'(r) > MAX_DIM)
			v = IW'(MAX_DIM - 1);
		else
			v = IW'(r - mfb_pkg::DIM_W'(1));
		return v;
	endfunction

	assign nr_m1 = dim_m1(rows_q);
	assign nk_m1 = dim_m1(inner_q);
	assign nc_m1 = dim_m1(cols_q);

	// loop limits per pass
	always_comb begin
		case (mode_q)
			mfb_pkg::MODE_FWD: begin lp = nr_m1; lq = nc_m1; lt = nk_m1; end
			mfb_pkg::MODE_BWA: begin lp = nr_m1; lq = nk_m1; lt = nc_m1; end
			mfb_pkg::MODE_BWB: begin lp = nk_m1; lq = nc_m1; lt = nr_m1; end
			default:           begin lp = '0;    lq = '0;    lt = '0;    end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign t_end    = (t_q == lt);
	assign q_end    = (q_q == lq);
	assign p_end    = (p_q == lp);
	assign clr_end  = (clr_q == AW'(DEPTH - 1));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= mfb_pkg::DIM_RESET;
			inner_q <= mfb_pkg::DIM_RESET;
			cols_q  <= mfb_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				mfb_pkg::REG_ROWS:  rows_q  <= cfg_data;
				mfb_pkg::REG_INNER: inner_q <= cfg_data;
				mfb_pkg::REG_COLS:  cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		case (state_q)
			S_CLR:   if (clr_end) state_d = S_IDLE;
			S_IDLE: begin
				if (in_fire) begin
					case (cmd)
						mfb_pkg::CMD_READ:  state_d = S_RD;
						mfb_pkg::CMD_CLEAR: state_d = S_CLR;
						mfb_pkg::CMD_FWD: begin
							state_d = S_RUN;
							mode_d  = mfb_pkg::MODE_FWD;
						end
						mfb_pkg::CMD_BWD: begin
							state_d = S_RUN;
							mode_d  = mfb_pkg::MODE_BWA;
						end
						default: ;
					endcase
				end
			end
			S_RD:    if (!stat.out_full) state_d = S_IDLE;
			S_RUN: begin
				if (t_end && q_end && p_end) begin
					if (mode_q == mfb_pkg::MODE_BWA)
						mode_d = mfb_pkg::MODE_BWB;
					else
						state_d = S_DRAIN;
				end
			end
			S_DRAIN: if (!stat.busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state, pass and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			mode_q  <= mfb_pkg::MODE_FWD;
			p_q     <= '0;
			q_q     <= '0;
			t_q     <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (state_q == S_CLR)
				clr_q <= clr_end ? '0 : clr_q + AW'(1);
			if (state_q == S_RUN) begin
				t_q <= t_end ? '0 : t_q + IW'(1);
				if (t_end) begin
					q_q <= q_end ? '0 : q_q + IW'(1);
					if (q_end)
						p_q <= p_end ? '0 : p_q + IW'(1);
				end
			end
		end
	end

	// commands to the datapath
	always_comb begin
		ctl.accept   = in_fire;
		ctl.issue    = (state_q == S_RUN);
		ctl.first    = (t_q == '0);
		ctl.last     = t_end;
		ctl.mode     = mode_q;
		ctl.clr_en   = (state_q == S_CLR);
		ctl.out_load = (state_q == S_RD) && !stat.out_full;
	end

	assign p_idx    = p_q;
	assign q_idx    = q_q;
	assign t_idx    = t_q;
	assign clr_addr = clr_q;

endmodule

### design/mfb_dp.sv
// Datapath of the matmul engine: six element memories, MAC pipeline, output register.
// Depends on mfb_pkg.
module mfb_dp #(
	parameter int MAX_DIM   = mfb_pkg::DEF_MAX_DIM,
	parameter int ELEM_BITS = mfb_pkg::DEF_ELEM_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mfb_pkg::ctl_t                      ctl,
	input  logic [$clog2(MAX_DIM)-1:0]         p_idx,
	input  logic [$clog2(MAX_DIM)-1:0]         q_idx,
	input  logic [$clog2(MAX_DIM)-1:0]         t_idx,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] clr_addr,
	input  logic [2:0]                         cmd,
	input  logic [2:0]                         row_index,
	input  logic [2:0]                         col_index,
	input  logic signed [ELEM_BITS-1:0]        element_value,
	input  logic [1:0]                         read_select,
	output mfb_pkg::stat_t                     stat,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mfb_pkg::DATA_W-1:0]  result_value
);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (ELEM_BITS < 16) ? ELEM_BITS : 16;
	localparam int DW    = mfb_pkg::DATA_W;
	localparam int PW    = 2 * SW;
	localparam int ACC_W = DW + $clog2(MAX_DIM) + 2;

	logic signed [SW-1:0] a_mem  [DEPTH];
	logic signed [SW-1:0] b_mem  [DEPTH];
	logic signed [SW-1:0] dc_mem [DEPTH];
	logic signed [DW-1:0] c_mem  [DEPTH];
	logic signed [DW-1:0] ga_mem [DEPTH];
	logic signed [DW-1:0] gb_mem [DEPTH];

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(int'(r) * MAX_DIM + int'(c));
	endfunction

	logic                  host_in, host_rd, load_en;
	logic [AW-1:0]         host_a;
	logic [AW-1:0]         a_ra, b_ra, dc_ra, g_ra, pq_a;
	logic signed [SW-1:0]  a_rd_s1, b_rd_s1, dc_rd_s1;
	logic signed [DW-1:0]  c_rd_s1, ga_rd_s1, gb_rd_s1;
	logic                  v_s1, first_s1, last_s1;
	mfb_pkg::mode_t        mode_s1, mode_s2, mode_s3;
	logic [AW-1:0]         dst_s1, dst_s2, dst_s3;
	logic signed [SW-1:0]  x_mul, y_mul;
	logic signed [DW-1:0]  base_mux;
	logic                  v_s2, first_s2, last_s2, last_s3;
	logic signed [PW-1:0]  prod_s2;
	logic signed [DW-1:0]  base_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DW-1:0]  sat_val;
	logic                  ovf;
	logic [1:0]            rsel_q;
	logic                  rin_q;
	logic                  out_valid_q;
	logic signed [DW-1:0]  out_q, rd_val;
	logic                  ga_we, gb_we, c_we;
	logic [AW-1:0]         g_wa;
	logic signed [DW-1:0]  g_wd;

	// host address decode; loads outside the array are dropped, reads there return zero
	assign host_in = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign host_a  = AW'(int'(row_index) * MAX_DIM + int'(col_index));
	assign host_rd = ctl.accept && (cmd == mfb_pkg::CMD_READ);
	assign load_en = ctl.accept && host_in;

	// operand addresses per pass
	assign pq_a  = addr_of(p_idx, q_idx);
	assign a_ra  = (ctl.mode == mfb_pkg::MODE_FWD) ? addr_of(p_idx, t_idx)
	                                               : addr_of(t_idx, p_idx);
	assign b_ra  = (ctl.mode == mfb_pkg::MODE_FWD) ? addr_of(t_idx, q_idx)
	                                               : addr_of(q_idx, t_idx);
	assign dc_ra = (ctl.mode == mfb_pkg::MODE_BWA) ? addr_of(p_idx, t_idx)
	                                               : addr_of(t_idx, q_idx);
	assign g_ra  = ctl.issue ? pq_a : host_a;

	// operand memories
	always_ff @(posedge clk) begin
		if (load_en && cmd == mfb_pkg::CMD_LOAD_A)
			a_mem[host_a] <= element_value[SW-1:0];
		a_rd_s1 <= a_mem[a_ra];
	end

	always_ff @(posedge clk) begin
		if (load_en && cmd == mfb_pkg::CMD_LOAD_B)
			b_mem[host_a] <= element_value[SW-1:0];
		b_rd_s1 <= b_mem[b_ra];
	end

	always_ff @(posedge clk) begin
		if (load_en && cmd == mfb_pkg::CMD_LOAD_DC)
			dc_mem[host_a] <= element_value[SW-1:0];
		dc_rd_s1 <= dc_mem[dc_ra];
	end

	// saturate the accumulator to 32 bits
	assign ovf     = !((&acc_q[ACC_W-1:DW-1]) || !(|acc_q[ACC_W-1:DW-1]));
	assign sat_val = !ovf ? acc_q[DW-1:0]
	               : (acc_q[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

	// result write ports; the clear sweep owns the gradient ports
	assign c_we  = last_s3 && (mode_s3 == mfb_pkg::MODE_FWD);
	assign ga_we = ctl.clr_en || (last_s3 && mode_s3 == mfb_pkg::MODE_BWA);
	assign gb_we = ctl.clr_en || (last_s3 && mode_s3 == mfb_pkg::MODE_BWB);
	assign g_wa  = ctl.clr_en ? clr_addr : dst_s3;
	assign g_wd  = ctl.clr_en ? '0 : sat_val;

	// result memories
	always_ff @(posedge clk) begin
		if (c_we)
			c_mem[dst_s3] <= sat_val;
		if (host_rd)
			c_rd_s1 <= c_mem[host_a];
	end

	always_ff @(posedge clk) begin
		if (ga_we)
			ga_mem[g_wa] <= g_wd;
		if (host_rd || ctl.issue)
			ga_rd_s1 <= ga_mem[g_ra];
	end

	always_ff @(posedge clk) begin
		if (gb_we)
			gb_mem[g_wa] <= g_wd;
		if (host_rd || ctl.issue)
			gb_rd_s1 <= gb_mem[g_ra];
	end

	// operand select for the multiplier
	always_comb begin
		case (mode_s1)
			mfb_pkg::MODE_FWD: begin x_mul = a_rd_s1; y_mul = b_rd_s1;  base_mux = '0;       end
			mfb_pkg::MODE_BWA: begin x_mul = b_rd_s1; y_mul = dc_rd_s1; base_mux = ga_rd_s1; end
			mfb_pkg::MODE_BWB: begin x_mul = a_rd_s1; y_mul = dc_rd_s1; base_mux = gb_rd_s1; end
			default:           begin x_mul = '0;      y_mul = '0;       base_mux = '0;       end
		endcase
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			v_s1    <= ctl.issue;
			v_s2    <= v_s1;
			last_s3 <= v_s2 && last_s2;
		end
	end

	// pipeline payload: issue -> read -> multiply -> accumulate -> write back
	always_ff @(posedge clk) begin
		first_s1 <= ctl.first;
		last_s1  <= ctl.last;
		mode_s1  <= ctl.mode;
		dst_s1   <= pq_a;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		mode_s2  <= mode_s1;
		dst_s2   <= dst_s1;
		prod_s2  <= x_mul * y_mul;
		base_s2  <= base_mux;
		mode_s3  <= mode_s2;
		dst_s3   <= dst_s2;
		if (v_s2)
			acc_q <= (first_s2 ? ACC_W'(base_s2) : acc_q) + ACC_W'(prod_s2);
	end

	// read word select
	always_comb begin
		case (rsel_q)
			mfb_pkg::SEL_C:  rd_val = c_rd_s1;
			mfb_pkg::SEL_GA: rd_val = ga_rd_s1;
			mfb_pkg::SEL_GB: rd_val = gb_rd_s1;
			default:         rd_val = '0;
		endcase
		if (!rin_q)
			rd_val = '0;
	end

	always_ff @(posedge clk) begin
		if (host_rd) begin
			rsel_q <= read_select;
			rin_q  <= host_in;
		end
		if (ctl.out_load)
			out_q <= rd_val;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign result_value  = out_q;
	assign stat.busy     = v_s1 || v_s2 || last_s3;
	assign stat.out_full = out_valid_q && !out_ready;

endmodule

### design/mfb_checker.sv
// Port-level checks of the matmul engine, bound to the top level.
// Depends on mfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfb_port_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [2:0]                        cmd,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [mfb_pkg::DATA_W-1:0] result_value
);
	logic in_fire, cmd_load, cmd_long;
	assign in_fire  = in_valid && in_ready;
	assign cmd_load = cmd inside {mfb_pkg::CMD_LOAD_A, mfb_pkg::CMD_LOAD_B, mfb_pkg::CMD_LOAD_DC};
	assign cmd_long = cmd inside {mfb_pkg::CMD_READ, mfb_pkg::CMD_FWD, mfb_pkg::CMD_BWD};

	// a waiting read word holds
	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value))
	// a load leaves the block ready for the next word
	`CHK_NEXT(a_load_quick, in_fire && cmd_load, in_ready)
	// a read or a compute command keeps the input closed next cycle
	`CHK_NEXT(a_busy_after, in_fire && cmd_long, !in_ready)
	// a read word appears only when the input was closed just before it
	`CHK_IMPL(a_out_origin, $rose(out_valid), $past(!in_ready))

endmodule

bind matmul_forward_backward mfb_port_checker u_mfb_chk (.*);

### tb/mfb_checker.sv
// Checker for the matmul / backprop engine: watches the input, config and result channels,
// keeps its own copy of the matrices and gradients, and compares every read word.
// Depends on mfb_pkg.
module mfb_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [2:0]                        cmd,
	input  logic [2:0]                        row_index,
	input  logic [2:0]                        col_index,
	input  logic signed [15:0]                element_value,
	input  logic [1:0]                        read_select,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [mfb_pkg::DATA_W-1:0] result_value,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfb_pkg::DIM_W-1:0]         cfg_data,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MD = mfb_pkg::DEF_MAX_DIM;
	localparam int NC = MD * MD;

	logic [mfb_pkg::DIM_W-1:0] rows_reg, inner_reg, cols_reg;
	logic signed [15:0] a_mem [NC];
	logic signed [15:0] b_mem [NC];
	logic signed [15:0] dc_mem [NC];
	logic signed [31:0] c_mem [NC];
	logic signed [31:0] ga_mem [NC];
	logic signed [31:0] gb_mem [NC];
	logic signed [31:0] read_expect_q [$];

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic int dim_of(input logic [mfb_pkg::DIM_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > MD)
			return MD;
		return int'(r);
	endfunction

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// C = A*B over the current dimensions
	function automatic void do_forward();
		int nr, nk, ncol;
		longint acc;
		nr = dim_of(rows_reg);
		nk = dim_of(inner_reg);
		ncol = dim_of(cols_reg);
		for (int i = 0; i < nr; i++)
			for (int j = 0; j < ncol; j++) begin
				acc = 0;
				for (int k = 0; k < nk; k++)
					acc += longint'(a_mem[i*MD+k]) * longint'(b_mem[k*MD+j]);
				c_mem[i*MD+j] = sat32(acc);
			end
	endfunction

	// gradient accumulation, both from the old gradient values, one saturation each
	function automatic void do_backward();
		int nr, nk, ncol;
		longint acc;
		logic signed [31:0] ga_new [NC];
		logic signed [31:0] gb_new [NC];
		nr = dim_of(rows_reg);
		nk = dim_of(inner_reg);
		ncol = dim_of(cols_reg);
		ga_new = ga_mem;
		gb_new = gb_mem;
		for (int i = 0; i < nr; i++)
			for (int k = 0; k < nk; k++) begin
				acc = longint'(ga_mem[i*MD+k]);
				for (int j = 0; j < ncol; j++)
					acc += longint'(b_mem[k*MD+j]) * longint'(dc_mem[i*MD+j]);
				ga_new[i*MD+k] = sat32(acc);
			end
		for (int k = 0; k < nk; k++)
			for (int j = 0; j < ncol; j++) begin
				acc = longint'(gb_mem[k*MD+j]);
				for (int i = 0; i < nr; i++)
					acc += longint'(a_mem[i*MD+k]) * longint'(dc_mem[i*MD+j]);
				gb_new[k*MD+j] = sat32(acc);
			end
		ga_mem = ga_new;
		gb_mem = gb_new;
	endfunction

	// predict and compare on every handshake
	always @(posedge clk or negedge arst_n) begin
		int idx;
		logic signed [31:0] want;
		if (!arst_n) begin
			rows_reg = mfb_pkg::DIM_RESET;
			inner_reg = mfb_pkg::DIM_RESET;
			cols_reg = mfb_pkg::DIM_RESET;
			for (int n = 0; n < NC; n++) begin
				a_mem[n] = '0;
				b_mem[n] = '0;
				dc_mem[n] = '0;
				c_mem[n] = '0;
				ga_mem[n] = '0;
				gb_mem[n] = '0;
			end
			read_expect_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (mfb_pkg::reg_t'(cfg_index))
					mfb_pkg::REG_ROWS:  rows_reg = cfg_data;
					mfb_pkg::REG_INNER: inner_reg = cfg_data;
					mfb_pkg::REG_COLS:  cols_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				idx = int'(row_index) * MD + int'(col_index);
				case (mfb_pkg::cmd_t'(cmd))
					mfb_pkg::CMD_LOAD_A:  a_mem[idx] = element_value;
					mfb_pkg::CMD_LOAD_B:  b_mem[idx] = element_value;
					mfb_pkg::CMD_LOAD_DC: dc_mem[idx] = element_value;
					mfb_pkg::CMD_FWD:     do_forward();
					mfb_pkg::CMD_BWD:     do_backward();
					mfb_pkg::CMD_READ: begin
						case (mfb_pkg::sel_t'(read_select))
							mfb_pkg::SEL_C:  want = c_mem[idx];
							mfb_pkg::SEL_GA: want = ga_mem[idx];
							mfb_pkg::SEL_GB: want = gb_mem[idx];
							default:         want = '0;
						endcase
						read_expect_q.push_back(want);
					end
					mfb_pkg::CMD_CLEAR: begin
						for (int n = 0; n < NC; n++) begin
							ga_mem[n] = '0;
							gb_mem[n] = '0;
						end
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (read_expect_q.size() == 0)
					report($sformatf("unexpected read word %h", result_value));
				else begin
					want = read_expect_q.pop_front();
					if (result_value !== want)
						report($sformatf("result_value %h, expected %h", result_value, want));
				end
			end
		end
		pending = read_expect_q.size();
	end

endmodule

### tb/tb_top.sv
// Top of the matmul / backprop testbench: clock, reset, stimulus and verdict.
// Depends on mfb_pkg, matmul_forward_backward and mfb_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [1:0] SEL_NONE   = 2'd3;
	localparam int SETTLE_CYCLES = 1200;   // longest compute plus margin
	localparam int DIM_BITS = mfb_pkg::DIM_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic [2:0] row_index = '0;
	logic [2:0] col_index = '0;
	logic signed [15:0] element_value = '0;
	logic [1:0] read_select = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [mfb_pkg::DATA_W-1:0] result_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_BITS-1:0] cfg_data = '0;
	int fail_count;
	int pending;
	int burst_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	matmul_forward_backward u_top (.*);

	mfb_checker u_chk (.*);

	// receiver: ready rate changes at random intervals
	always @(posedge clk) begin
		int cnt;
		int pct;
		if (cnt == 0) begin
			cnt = $urandom_range(50, 400);
			case ($urandom_range(0, 3))
				0: pct = 100;
				1: pct = 75;
				2: pct = 40;
				default: pct = 10;
			endcase
		end
		cnt--;
		out_ready <= ($urandom_range(0, 99) < pct);
	end

	// one command word, sent in bursts with random gaps between them
	task automatic send_word(input logic [2:0] c, input logic [2:0] r, input logic [2:0] k,
			input logic [15:0] v, input logic [1:0] s);
		int gap;
		logic rdy;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		row_index <= r;
		col_index <= k;
		element_value <= v;
		read_select <= s;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// drain every read and let any compute finish
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input mfb_pkg::reg_t idx, input logic [DIM_BITS-1:0] d);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		int r;
		logic [DIM_BITS-1:0] dims [10][3];
		dims = '{'{8, 8, 8}, '{1, 1, 1}, '{0, 0, 0}, '{15, 15, 15}, '{3, 5, 2},
			'{8, 1, 8}, '{1, 8, 1}, '{0, 9, 4}, '{5, 2, 7}, '{6, 7, 3}};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every element: A and B at most negative, dC at most positive
		for (int n = 0; n < 64; n++) begin
			send_word(mfb_pkg::CMD_LOAD_A, 3'(n / 8), 3'(n % 8), 16'h8000, mfb_pkg::SEL_C);
			send_word(mfb_pkg::CMD_LOAD_B, 3'(n / 8), 3'(n % 8), 16'h8000, mfb_pkg::SEL_C);
			send_word(mfb_pkg::CMD_LOAD_DC, 3'(n / 8), 3'(n % 8), 16'h7fff, mfb_pkg::SEL_C);
		end
		// directed: saturating forward, double backward, every read select, clear, unused cmd
		send_word(mfb_pkg::CMD_READ, 3'd0, 3'd0, 16'h0, mfb_pkg::SEL_GA);
		send_word(mfb_pkg::CMD_FWD, 3'd0, 3'd0, 16'h0, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_READ, 3'd7, 3'd7, 16'h0, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_BWD, 3'd0, 3'd0, 16'h0, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_READ, 3'd3, 3'd4, 16'h0, mfb_pkg::SEL_GA);
		send_word(mfb_pkg::CMD_READ, 3'd4, 3'd3, 16'h0, mfb_pkg::SEL_GB);
		send_word(mfb_pkg::CMD_BWD, 3'd0, 3'd0, 16'h0, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_READ, 3'd0, 3'd7, 16'h0, mfb_pkg::SEL_GA);
		send_word(mfb_pkg::CMD_READ, 3'd7, 3'd0, 16'h0, mfb_pkg::SEL_GB);
		send_word(mfb_pkg::CMD_READ, 3'd2, 3'd2, 16'h0, SEL_NONE);
		send_word(CMD_UNUSED, 3'd5, 3'd5, 16'hffff, SEL_NONE);
		send_word(mfb_pkg::CMD_LOAD_A, 3'd0, 3'd0, 16'h7fff, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_LOAD_A, 3'd0, 3'd1, 16'h0001, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_FWD, 3'd0, 3'd0, 16'h0, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_READ, 3'd0, 3'd5, 16'h0, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_CLEAR, 3'd0, 3'd0, 16'h0, mfb_pkg::SEL_C);
		send_word(mfb_pkg::CMD_READ, 3'd3, 3'd3, 16'h0, mfb_pkg::SEL_GA);
		send_word(mfb_pkg::CMD_READ, 3'd3, 3'd3, 16'h0, mfb_pkg::SEL_GB);

		// random phases, one dimension setting each
		for (int p = 0; p < 10; p++) begin
			settle();
			cfg_write(mfb_pkg::REG_ROWS, dims[p][0]);
			cfg_write(mfb_pkg::REG_INNER, dims[p][1]);
			cfg_write(mfb_pkg::REG_COLS, dims[p][2]);
			if (p == 4)
				cfg_write(mfb_pkg::reg_t'(2'd3), DIM_BITS'($urandom));
			cfg_valid <= 1'b0;
			@(posedge clk);
			for (int n = 0; n < 140; n++) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					send_word(mfb_pkg::CMD_LOAD_A, 3'($urandom), 3'($urandom),
						pick_value(), 2'($urandom));
				else if (r < 30)
					send_word(mfb_pkg::CMD_LOAD_B, 3'($urandom), 3'($urandom),
						pick_value(), 2'($urandom));
				else if (r < 45)
					send_word(mfb_pkg::CMD_LOAD_DC, 3'($urandom), 3'($urandom),
						pick_value(), 2'($urandom));
				else if (r < 50)
					send_word(mfb_pkg::CMD_FWD, 3'($urandom), 3'($urandom),
						16'($urandom), 2'($urandom));
				else if (r < 55)
					send_word(mfb_pkg::CMD_BWD, 3'($urandom), 3'($urandom),
						16'($urandom), 2'($urandom));
				else if (r < 92)
					send_word(mfb_pkg::CMD_READ, 3'($urandom), 3'($urandom),
						16'($urandom), 2'($urandom));
				else if (r < 95)
					send_word(mfb_pkg::CMD_CLEAR, 3'($urandom), 3'($urandom),
						16'($urandom), 2'($urandom));
				else
					send_word(CMD_UNUSED, 3'($urandom), 3'($urandom),
						16'($urandom), 2'($urandom));
			end
		end
		settle();

		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end
endmodule
